### rtl/smeu_pkg.sv
package smeu_pkg;

  localparam int unsigned StackDepthDef = 64;
  localparam int unsigned SlotCountDef  = 64;

  localparam logic [4:0] CmdPush   = 5'd0;
  localparam logic [4:0] CmdDup    = 5'd1;
  localparam logic [4:0] CmdSwap   = 5'd2;
  localparam logic [4:0] CmdDrop   = 5'd3;
  localparam logic [4:0] CmdTuck   = 5'd4;
  localparam logic [4:0] CmdOver   = 5'd5;
  localparam logic [4:0] CmdNip    = 5'd6;
  localparam logic [4:0] CmdAdd    = 5'd7;
  localparam logic [4:0] CmdSub    = 5'd8;
  localparam logic [4:0] CmdMul    = 5'd9;
  localparam logic [4:0] CmdDiv    = 5'd10;
  localparam logic [4:0] CmdMod    = 5'd11;
  localparam logic [4:0] CmdEq     = 5'd12;
  localparam logic [4:0] CmdNe     = 5'd13;
  localparam logic [4:0] CmdLt     = 5'd14;
  localparam logic [4:0] CmdLe     = 5'd15;
  localparam logic [4:0] CmdGt     = 5'd16;
  localparam logic [4:0] CmdGe     = 5'd17;
  localparam logic [4:0] CmdZeroChk = 5'd18;
  localparam logic [4:0] CmdDefine = 5'd19;
  localparam logic [4:0] CmdLoad   = 5'd20;
  localparam logic [4:0] CmdStore  = 5'd21;
  localparam logic [4:0] CmdPrint  = 5'd22;

  localparam logic [2:0] StOk      = 3'd0;
  localparam logic [2:0] StUnder   = 3'd1;
  localparam logic [2:0] StOver    = 3'd2;
  localparam logic [2:0] StDivZero = 3'd3;
  localparam logic [2:0] StUndef   = 3'd4;
  localparam logic [2:0] StRedef   = 3'd5;
  localparam logic [2:0] StHalted  = 3'd6;

  // Commands from controller to datapath.
  typedef struct packed {
    logic load_item;   // capture the item and start the operand reads
    logic exec;        // commit the operation
    logic div_start;   // start the shared divider
  } smeu_cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic div_needed;  // accepted op will run the divider
    logic div_done;
  } smeu_stat_t;

endpackage

### rtl/smeu_div.sv
module smeu_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] dividend_i,
  input  logic [31:0] divisor_i,
  output logic        done_o,
  output logic [31:0] quot_o,
  output logic [31:0] rem_o
);
  // Restoring divider on magnitudes, one quotient bit per cycle.
  logic        busy_q, busy_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [31:0] quo_q, quo_d;
  logic [32:0] rem_q, rem_d;
  logic [31:0] dvs_q, dvs_d;
  logic        qneg_q, qneg_d, rneg_q, rneg_d;
  logic        done_q, done_d;
  logic [32:0] trial;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    qneg_d = qneg_q;
    rneg_d = rneg_q;
    done_d = 1'b0;
    trial  = {rem_q[31:0], quo_q[31]} - {1'b0, dvs_q};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = 6'd0;
      quo_d  = dividend_i[31] ? (32'd0 - dividend_i) : dividend_i;
      dvs_d  = divisor_i[31] ? (32'd0 - divisor_i) : divisor_i;
      rem_d  = 33'd0;
      qneg_d = dividend_i[31] ^ divisor_i[31];
      rneg_d = dividend_i[31];
    end else if (busy_q) begin
      if (trial[32]) begin
        rem_d = {rem_q[31:0], quo_q[31]};
        quo_d = {quo_q[30:0], 1'b0};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[30:0], 1'b1};
      end
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'd31) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 6'd0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q  <= quo_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
    qneg_q <= qneg_d;
    rneg_q <= rneg_d;
  end

  assign done_o = done_q;
  assign quot_o = qneg_q ? (32'd0 - quo_q) : quo_q;
  assign rem_o  = rneg_q ? (32'd0 - rem_q[31:0]) : rem_q[31:0];
endmodule

### rtl/smeu_ctrl.sv
module smeu_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  smeu_pkg::smeu_stat_t stat_i,
  output smeu_pkg::smeu_cmd_t  cmd_o
);
  import smeu_pkg::*;

  localparam logic [1:0] SIdle = 2'd0;
  localparam logic [1:0] SExec = 2'd1;
  localparam logic [1:0] SDiv  = 2'd2;
  localparam logic [1:0] SWait = 2'd3;

  logic [1:0] state_q, state_d;
  logic       ovalid_q, ovalid_d;
  logic       go;

  // A new item is taken when idle and the result register is free or being drained.
  assign in_ready_o = (state_q == SIdle) && (!ovalid_q || out_ready_i);
  assign go         = in_valid_i && in_ready_o;

  always_comb begin
    state_d  = state_q;
    ovalid_d = ovalid_q;
    cmd_o    = '0;
    if (ovalid_q && out_ready_i) ovalid_d = 1'b0;
    unique case (state_q)
      SIdle: begin
        if (go) begin
          cmd_o.load_item = 1'b1;
          state_d = SExec;
        end
      end
      SExec: begin
        if (stat_i.div_needed) begin
          cmd_o.div_start = 1'b1;
          state_d = SDiv;
        end else begin
          cmd_o.exec = 1'b1;
          ovalid_d = 1'b1;
          state_d = SIdle;
        end
      end
      SDiv: begin
        if (stat_i.div_done) state_d = SWait;
      end
      SWait: begin
        cmd_o.exec = 1'b1;
        ovalid_d = 1'b1;
        state_d = SIdle;
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= SIdle;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
    end
  end

  assign out_valid_o = ovalid_q;

`ifndef SYNTHESIS
  a_result_only_after_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ovalid_q) |-> $past(cmd_o.exec)) else $error("result without commit");
  a_no_take_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != SIdle) |-> !in_ready_o) else $error("ready while busy");
  a_exec_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.exec |=> ovalid_q) else $error("commit lost result");
`endif
endmodule

### rtl/smeu_dp.sv
module smeu_dp #(
  parameter int unsigned StackDepth = smeu_pkg::StackDepthDef,
  parameter int unsigned SlotCount  = smeu_pkg::SlotCountDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [4:0]           command_i,
  input  logic signed [31:0]   literal_i,
  input  logic [5:0]           slot_i,
  input  smeu_pkg::smeu_cmd_t  cmd_i,
  output smeu_pkg::smeu_stat_t stat_o,
  output logic [2:0]           status_o,
  output logic                 print_valid_o,
  output logic signed [31:0]   print_value_o,
  output logic [6:0]           depth_o
);
  import smeu_pkg::*;

  localparam int unsigned SpW = $clog2(StackDepth + 1);
  localparam int unsigned AW  = $clog2(StackDepth);
  localparam int unsigned SlW = (SlotCount > 1) ? $clog2(SlotCount) : 1;

  // The top two entries live in registers; the rest sit in a memory below.
  logic [31:0] mem_q [StackDepth];
  logic [31:0] slot_mem_q [SlotCount];
  logic [SlotCount-1:0] sdef_q;
  logic [31:0] t_q, s_q, u_q;   // top, second, memory read of third
  logic [SpW-1:0] sp_q;
  logic        halted_q;
  logic [4:0]  cmd_q;
  logic [31:0] lit_q;
  logic [5:0]  slot_q;
  logic [31:0] slot_rd_q;
  logic [2:0]  status_q;
  logic        pvalid_q;
  logic [31:0] pval_q;

  logic        div_done;
  logic [31:0] quot, remd;
  logic [SpW-1:0] rd_ptr;

  // Third entry (index sp-3) is read when the item is loaded, ahead of commit.
  assign rd_ptr = (sp_q >= SpW'(3)) ? (sp_q - SpW'(3)) : '0;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      cmd_q  <= command_i;
      lit_q  <= literal_i;
      slot_q <= slot_i;
      u_q    <= mem_q[rd_ptr[AW-1:0]];
      slot_rd_q <= slot_mem_q[SlW'(slot_i)];
    end
  end

  smeu_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cmd_i.div_start),
    .dividend_i(t_q),
    .divisor_i (s_q),
    .done_o    (div_done),
    .quot_o    (quot),
    .rem_o     (remd)
  );

  // Status evaluation.
  logic [SpW:0] spx;
  logic         slot_ok, sdef;
  logic [2:0]   st;
  logic [1:0]   pops, pushes;

  assign spx     = {1'b0, sp_q};
  assign slot_ok = ({26'd0, slot_q} < 32'(SlotCount));
  assign sdef    = slot_ok && sdef_q[SlW'(slot_q)];

  always_comb begin
    pops = 2'd0;
    pushes = 2'd0;
    case (cmd_q) inside
      CmdPush, CmdLoad: begin pops = 2'd0; pushes = 2'd1; end
      CmdDup: begin pops = 2'd1; pushes = 2'd2; end
      CmdSwap: begin pops = 2'd2; pushes = 2'd2; end
      CmdDrop, CmdDefine, CmdStore, CmdPrint: begin pops = 2'd1; pushes = 2'd0; end
      CmdTuck, CmdOver: begin pops = 2'd2; pushes = 2'd3; end
      CmdZeroChk: begin pops = 2'd1; pushes = 2'd1; end
      default: begin
        if (cmd_q >= CmdNip && cmd_q <= CmdGe) begin
          pops = 2'd2; pushes = 2'd1;
        end
      end
    endcase
  end

  logic [2:0] fit;
  always_comb begin
    if (spx < (SpW+1)'(pops)) fit = StUnder;
    else if (spx - (SpW+1)'(pops) + (SpW+1)'(pushes) > (SpW+1)'(StackDepth)) fit = StOver;
    else fit = StOk;
    if (halted_q) st = StHalted;
    else begin
      case (cmd_q) inside
        CmdDefine: st = sdef ? StRedef : (!slot_ok ? StUndef : fit);
        CmdLoad:   st = !sdef ? StUndef : fit;
        CmdStore:  st = (fit == StOk && !sdef) ? StUndef : fit;
        CmdDiv, CmdMod: st = (fit == StOk && s_q == 32'd0) ? StDivZero : fit;
        default:   st = fit;
      endcase
    end
  end

  assign stat_o.div_needed = (st == StOk) && (cmd_q == CmdDiv || cmd_q == CmdMod);
  assign stat_o.div_done   = div_done;

  // Result of two-operand ops.
  logic signed [31:0] ts, ss;
  logic [31:0] r;
  logic [31:0] prod_q;
  assign ts = t_q;
  assign ss = s_q;
  always_ff @(posedge clk_i) prod_q <= t_q * s_q;
  always_comb begin
    case (cmd_q)
      CmdAdd: r = t_q + s_q;
      CmdSub: r = s_q - t_q;
      CmdMul: r = prod_q;
      CmdDiv: r = quot;
      CmdMod: r = remd;
      CmdEq:  r = {31'd0, ts == ss};
      CmdNe:  r = {31'd0, ts != ss};
      CmdLt:  r = {31'd0, ts < ss};
      CmdLe:  r = {31'd0, ts <= ss};
      CmdGt:  r = {31'd0, ts > ss};
      default: r = {31'd0, ts >= ss};
    endcase
  end

  // Commit: new top, second, pointer, and at most one memory write.
  logic [31:0] t_d, s_d, wdata;
  logic [SpW-1:0] sp_d, waddr;
  logic        we, ok;
  always_comb begin
    ok = (st == StOk) && (cmd_q <= CmdPrint);
    t_d = t_q; s_d = s_q; sp_d = sp_q;
    we = 1'b0; waddr = sp_q - SpW'(2); wdata = s_q;
    if (ok) begin
      case (cmd_q) inside
        CmdPush, CmdDup, CmdLoad, CmdOver: begin
          // Old second spills to memory.
          we = (sp_q >= SpW'(2));
          t_d = (cmd_q == CmdPush) ? lit_q : (cmd_q == CmdLoad) ? slot_rd_q :
                (cmd_q == CmdOver) ? s_q : t_q;
          s_d = t_q;
          sp_d = sp_q + SpW'(1);
        end
        CmdSwap: begin t_d = s_q; s_d = t_q; end
        CmdTuck: begin
          // a b -- b a b: second and top stay, a copy of top spills below them.
          we = 1'b1; wdata = t_q;
          s_d = s_q; t_d = t_q;
          sp_d = sp_q + SpW'(1);
        end
        CmdZeroChk: t_d = {31'd0, t_q == 32'd0};
        CmdNip: begin t_d = t_q; s_d = u_q; sp_d = sp_q - SpW'(1); end
        CmdDrop, CmdDefine, CmdStore, CmdPrint: begin
          t_d = s_q; s_d = u_q; sp_d = sp_q - SpW'(1);
        end
        default: begin t_d = r; s_d = u_q; sp_d = sp_q - SpW'(1); end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      t_q <= t_d;
      s_q <= s_d;
      if (we) mem_q[waddr[AW-1:0]] <= wdata;
      if (ok && (cmd_q == CmdDefine || cmd_q == CmdStore))
        slot_mem_q[SlW'(slot_q)] <= t_q;
      pvalid_q <= ok && (cmd_q == CmdPrint);
      pval_q   <= (ok && cmd_q == CmdPrint) ? t_q : 32'd0;
      status_q <= st;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_q     <= '0;
      halted_q <= 1'b0;
      sdef_q   <= '0;
    end else if (cmd_i.exec) begin
      sp_q <= sp_d;
      if (st != StOk) halted_q <= 1'b1;
      if (ok && cmd_q == CmdDefine) sdef_q[SlW'(slot_q)] <= 1'b1;
    end
  end

  assign status_o      = status_q;
  assign print_valid_o = pvalid_q;
  assign print_value_o = pval_q;
  assign depth_o       = 7'(sp_q);

`ifndef SYNTHESIS
  a_sp_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= SpW'(StackDepth)) else $error("stack pointer out of range");
  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_q |=> halted_q) else $error("halt cleared");
  a_halt_freezes_sp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(halted_q) |-> $stable(sp_q)) else $error("state moved while halted");
`endif
endmodule

### rtl/stack_machine_execute_unit_core.sv
// Channel | Signals                                     | Direction
// in      | in_valid_i/in_ready_o, command/lit/slot     | to block
// out     | out_valid_o/out_ready_i, status/print/depth | from block
// Most items go through an operand read, then a commit; a result register
// frees the input once it is taken. Mul uses a registered product.
// Div and mod run a one-bit-per-cycle divider before the commit.
// Reset clears the stack pointer, halt flag and slot defined bits.
// A stalled output holds the result and the input stays not ready.
module stack_machine_execute_unit_core #(
  parameter int unsigned StackDepth = smeu_pkg::StackDepthDef,
  parameter int unsigned SlotCount  = smeu_pkg::SlotCountDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [4:0]         command_i,
  input  logic signed [31:0] literal_i,
  input  logic [5:0]         slot_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [2:0]         status_o,
  output logic               print_valid_o,
  output logic signed [31:0] print_value_o,
  output logic [6:0]         depth_o
);
  import smeu_pkg::*;

  smeu_cmd_t  cmd;
  smeu_stat_t stat;

  smeu_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  smeu_dp #(.StackDepth(StackDepth), .SlotCount(SlotCount)) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .command_i    (command_i),
    .literal_i    (literal_i),
    .slot_i       (slot_i),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .status_o     (status_o),
    .print_valid_o(print_valid_o),
    .print_value_o(print_value_o),
    .depth_o      (depth_o)
  );
endmodule
